// ===== hdl/plyf_pkg.sv =====
// Package for the Playfair digraph cipher: letter codes, grid layout,
// register indexes and the transaction structs of the ports.
// No dependencies; used by plyf_subst and playfair_digraph_cipher.
package plyf_pkg;

  localparam int unsigned LetterW = 5;
  localparam int unsigned GridDim = 5;
  localparam int unsigned RowW    = GridDim * LetterW;
  localparam int unsigned PosW    = 3;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [LetterW-1:0] letter_t;
  typedef logic [PosW-1:0]    pos_t;

  // Grid rows; column 0 of each row sits in the low bits.
  typedef logic [GridDim-1:0][RowW-1:0] grid_t;

  // Letter codes with a special role.
  localparam letter_t LetterI = letter_t'(8);
  localparam letter_t LetterJ = letter_t'(9);
  localparam letter_t LetterQ = letter_t'(16);
  localparam letter_t LetterX = letter_t'(23);
  localparam letter_t LetterZ = letter_t'(25);

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgGridRowZero  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGridRowFour  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDecryptMode  = 3'd5;

  // The reset grid holds the codes 0 to 25 without 9 (J) in row-major order.
  localparam grid_t GridReset = {25'd27025109, 25'd21613104, 25'd16201099,
                                 25'd10755269, 25'd4294688};

  typedef struct packed {
    letter_t text_letter;
    logic    message_end;
  } in_t;

  typedef struct packed {
    letter_t cipher_letter;
    logic    final_letter;
  } out_t;

  // Two letters of the regrouped stream.
  typedef struct packed {
    letter_t first;
    letter_t second;
  } digraph_t;

endpackage

// ===== hdl/plyf_subst.sv =====
// Playfair substitution of one digraph through the 5x5 key grid.
// Purely combinational; depends on plyf_pkg.
module plyf_subst (
  input  plyf_pkg::grid_t    grid_i,
  input  logic               decrypt_i,
  input  plyf_pkg::digraph_t plain_i,
  output plyf_pkg::digraph_t cipher_o
);
  import plyf_pkg::*;

  typedef struct packed {
    pos_t row;
    pos_t col;
  } cell_pos_t;

  // Compare the letter against every cell; the first match in row-major
  // order wins, and a letter that is absent sits at row 0, column 0.
  function automatic cell_pos_t locate(grid_t g, letter_t l);
    cell_pos_t p;
    logic      found;
    p     = '0;
    found = 1'b0;
    for (int r = 0; r < GridDim; r++) begin
      for (int c = 0; c < GridDim; c++) begin
        if (!found && g[r][c*LetterW +: LetterW] == l) begin
          found = 1'b1;
          p.row = pos_t'(r);
          p.col = pos_t'(c);
        end
      end
    end
    return p;
  endfunction

  // Read one cell by an AND-OR select over the whole grid.
  function automatic letter_t cell_at(grid_t g, cell_pos_t p);
    letter_t v;
    v = '0;
    for (int r = 0; r < GridDim; r++) begin
      for (int c = 0; c < GridDim; c++) begin
        if (p.row == pos_t'(r) && p.col == pos_t'(c)) begin
          v = g[r][c*LetterW +: LetterW];
        end
      end
    end
    return v;
  endfunction

  // Shift one place along a row or column, wrapping round the grid.
  function automatic pos_t shift_pos(pos_t x, logic back);
    pos_t y;
    if (back) begin
      y = (x == '0) ? pos_t'(GridDim - 1) : x - pos_t'(1);
    end else begin
      y = (x == pos_t'(GridDim - 1)) ? '0 : x + pos_t'(1);
    end
    return y;
  endfunction

  cell_pos_t pos_a, pos_b;
  cell_pos_t new_a, new_b;

  assign pos_a = locate(grid_i, plain_i.first);
  assign pos_b = locate(grid_i, plain_i.second);

  // Same row shifts the columns, same column shifts the rows, and
  // otherwise the two columns are exchanged.
  always_comb begin
    new_a = pos_a;
    new_b = pos_b;
    priority if (pos_a.row == pos_b.row) begin
      new_a.col = shift_pos(pos_a.col, decrypt_i);
      new_b.col = shift_pos(pos_b.col, decrypt_i);
    end else if (pos_a.col == pos_b.col) begin
      new_a.row = shift_pos(pos_a.row, decrypt_i);
      new_b.row = shift_pos(pos_b.row, decrypt_i);
    end else begin
      new_a.col = pos_b.col;
      new_b.col = pos_a.col;
    end
  end

  assign cipher_o.first  = cell_at(grid_i, new_a);
  assign cipher_o.second = cell_at(grid_i, new_b);

endmodule

// ===== hdl/playfair_digraph_cipher.sv =====
// Top level of the Playfair digraph cipher: letter pairing, filler and
// padding, digraph queue, output letter register and key grid registers.
// Depends on plyf_pkg and plyf_subst.

// An input transaction carries one message letter; it produces zero, two
// or four output letters, always whole digraphs, and message_end closes
// the message with a Z pad where needed and a final_letter mark on its
// last output letter. The output port moves one letter a cycle while
// out_ready_i is high and digraphs are queued. An item yields 0, 2 or 4
// letters, a pair of ordinary letters yields one digraph, and a doubled
// pair takes a filler. An item's digraphs pass first into the digraph
// queue, then through the grid substitution into the output register.
// The queue holds the digraphs of one item while the previous digraph
// is still being delivered, so input and output overlap.
// Configuration writes are always taken at once and belong in idle time.
module playfair_digraph_cipher (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  plyf_pkg::in_t                         in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output plyf_pkg::out_t                        out_data_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [plyf_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [plyf_pkg::RowW-1:0]             cfg_data_i
);
  import plyf_pkg::*;

  // Configuration registers.
  grid_t grid_q;
  logic  decrypt_q;

  // Pairing state of the message.
  letter_t first_q, first_d;
  logic    odd_q, odd_d;
  letter_t pend_q, pend_d;
  logic    pend_valid_q, pend_valid_d;

  // Digraph queue holding the output of one item.
  logic     job_valid_q;
  logic     job_two_q;
  logic     job_last_q;
  digraph_t job_dg_q [2];

  // Output register holding one substituted digraph.
  logic     out_valid_q;
  logic     out_idx_q;
  logic     out_fin_q;
  digraph_t out_dg_q;

  logic     in_acc, out_acc, cfg_acc;
  logic     pair_free, xfer;
  letter_t  letter;
  logic     last;
  letter_t  p [4];
  letter_t  s [4];
  logic [1:0] plen;
  logic [2:0] slen;
  logic [2:0] tot;
  logic [1:0] n_dg;
  digraph_t subst_dg;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q    <= GridReset;
      decrypt_q <= 1'b0;
    end else if (cfg_acc) begin
      if (cfg_index_i <= CfgGridRowFour) begin
        grid_q[cfg_index_i] <= cfg_data_i;
      end else if (cfg_index_i == CfgDecryptMode) begin
        decrypt_q <= cfg_data_i[0];
      end
    end
  end

  // Handshakes between input, queue and output register.
  assign pair_free  = !out_valid_q || (out_ready_i && out_idx_q);
  assign xfer       = job_valid_q && pair_free;
  assign in_ready_o = !job_valid_q || (xfer && !job_two_q);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_o && out_ready_i;

  assign letter = (in_data_i.text_letter == LetterJ) ? LetterI : in_data_i.text_letter;
  assign last   = in_data_i.message_end;

  // Letters that this item pushes into the regrouped stream.
  always_comb begin
    p[0] = letter;
    p[1] = letter;
    p[2] = letter;
    p[3] = LetterZ;
    if (!odd_q) begin
      plen = last ? 2'd1 : 2'd0;
    end else begin
      p[0] = first_q;
      if (letter == first_q) begin
        p[1] = (letter == LetterX) ? LetterQ : LetterX;
        plen = 2'd3;
      end else begin
        plen = 2'd2;
      end
    end
  end

  // Stream after any pending letter, padded with Z at message end.
  always_comb begin
    if (pend_valid_q) begin
      s[0] = pend_q;
      s[1] = p[0];
      s[2] = p[1];
      s[3] = p[2];
    end else begin
      s[0] = p[0];
      s[1] = p[1];
      s[2] = p[2];
      s[3] = p[3];
    end
    slen = {1'b0, plen} + {2'b00, pend_valid_q};
    tot  = slen;
    if (last && slen[0]) begin
      tot = slen + 3'd1;
      if (slen == 3'd1) begin
        s[1] = LetterZ;
      end else begin
        s[3] = LetterZ;
      end
    end
    n_dg = tot[2:1];
  end

  // Next pairing state; the end of a message returns all of it to reset.
  always_comb begin
    first_d      = first_q;
    odd_d        = !odd_q;
    pend_d       = pend_q;
    pend_valid_d = 1'b0;
    if (!odd_q) begin
      first_d = letter;
    end
    if (slen[0]) begin
      pend_d       = (slen == 3'd1) ? s[0] : s[2];
      pend_valid_d = 1'b1;
    end
    if (last) begin
      first_d      = '0;
      odd_d        = 1'b0;
      pend_d       = '0;
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q      <= '0;
      odd_q        <= 1'b0;
      pend_q       <= '0;
      pend_valid_q <= 1'b0;
    end else if (in_acc) begin
      first_q      <= first_d;
      odd_q        <= odd_d;
      pend_q       <= pend_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // Digraph queue: the second digraph moves forward once the first leaves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      job_two_q   <= 1'b0;
      job_last_q  <= 1'b0;
    end else begin
      if (xfer) begin
        if (job_two_q) begin
          job_two_q <= 1'b0;
        end else begin
          job_valid_q <= 1'b0;
        end
      end
      if (in_acc && n_dg != 2'd0) begin
        job_valid_q <= 1'b1;
        job_two_q   <= n_dg[1];
        job_last_q  <= last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && n_dg != 2'd0) begin
      job_dg_q[0] <= '{first: s[0], second: s[1]};
      job_dg_q[1] <= '{first: s[2], second: s[3]};
    end else if (xfer && job_two_q) begin
      job_dg_q[0] <= job_dg_q[1];
    end
  end

  plyf_subst u_subst (
    .grid_i    (grid_q),
    .decrypt_i (decrypt_q),
    .plain_i   (job_dg_q[0]),
    .cipher_o  (subst_dg)
  );

  // Output register: a digraph goes out as two letter transactions.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_idx_q   <= 1'b0;
      out_fin_q   <= 1'b0;
    end else if (xfer) begin
      out_valid_q <= 1'b1;
      out_idx_q   <= 1'b0;
      out_fin_q   <= job_last_q && !job_two_q;
    end else if (out_acc) begin
      if (out_idx_q) begin
        out_valid_q <= 1'b0;
      end else begin
        out_idx_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer) begin
      out_dg_q <= subst_dg;
    end
  end

  assign out_valid_o              = out_valid_q;
  assign out_data_o.cipher_letter = out_idx_q ? out_dg_q.second : out_dg_q.first;
  assign out_data_o.final_letter  = out_fin_q && out_idx_q;

  // The final mark only ever sits on the second letter of a digraph.
  a_final_on_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_data_o.final_letter |-> out_idx_q)
    else $error("final letter flagged on first letter of a digraph");

  // A second queued digraph always belongs to a valid queue entry.
  a_two_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_two_q |-> job_valid_q)
    else $error("second digraph queued without a valid entry");

  // The end of a message leaves no pairing state behind.
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.message_end) |=> (!odd_q && !pend_valid_q))
    else $error("pairing state survived the end of a message");

  // Queued work is kept while the output register is still busy.
  a_job_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_q && !pair_free) |=> job_valid_q)
    else $error("queued digraph lost while output was busy");

  // A queued digraph that may move on is always moved on.
  a_job_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("idle output register not refilled from the queue");

endmodule
